// File: design/tfn_pkg.sv
`default_nettype none
package tfn_pkg;
  localparam int unsigned VERTEX_DEPTH_DEF  = 1024;
  localparam int unsigned SURFACE_DEPTH_DEF = 1024;
  localparam int unsigned COORD_WIDTH_DEF   = 16;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned NRM_W  = 16;
  localparam int unsigned MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_WR_VERTEX  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WR_SURFACE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPUTE    = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  vertex_index;
    logic [IDX_W-1:0]  surface_index;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_z;
    logic [IDX_W-1:0]  corner_a;
    logic [IDX_W-1:0]  corner_b;
    logic [IDX_W-1:0]  corner_c;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] out_vertex_a;
    logic [IDX_W-1:0] out_vertex_b;
    logic [IDX_W-1:0] out_vertex_c;
    logic [NRM_W-1:0] normal_x;
    logic [NRM_W-1:0] normal_y;
    logic [NRM_W-1:0] normal_z;
    logic             degenerate;
  } out_item_t;

  // start/busy/done handshake between the top level and the normalizer
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } nrm_ctl_t;
endpackage
`default_nettype wire

// File: design/tfn_if.sv
`default_nettype none
interface tfn_in_if;
  logic               valid;
  logic               ready;
  tfn_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tfn_out_if;
  logic               valid;
  logic               ready;
  tfn_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/tfn_norm.sv
`default_nettype none
// Normalizes a cross product: shift alignment one bit a cycle, squares via a
// shared 31x31 multiplier one component a cycle, a radix-2 square root one
// result bit a cycle, then restoring division one quotient bit a cycle.
module tfn_norm #(
  parameter int unsigned MW = 49
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [MW-1:0] mag0_i,
  input  wire logic [MW-1:0] mag1_i,
  input  wire logic [MW-1:0] mag2_i,
  output logic               done_o,
  output logic               busy_o,
  output logic [15:0]        q0_o,
  output logic [15:0]        q1_o,
  output logic [15:0]        q2_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ALN  = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]    st_q, st_d;
  logic [MW-1:0] m_q [3];
  logic [MW-1:0] m_d [3];
  logic [MW-1:0] mx;
  logic [1:0]    ci_q, ci_d;
  logic [5:0]    cnt_q, cnt_d;
  logic [62:0]   sum_q, sum_d;     // sum of squares, < 3*2^60
  logic [62:0]   rem_q, rem_d;     // sqrt remainder
  logic [31:0]   root_q, root_d;
  logic [45:0]   dr_q, dr_d;       // division partial remainder
  logic [45:0]   num_q, num_d;
  logic [15:0]   q_q [3];
  logic [15:0]   q_d [3];
  logic [61:0]   prod;
  logic [63:0]   trial;
  logic [46:0]   dtry;
  logic [46:0]   numer;
  logic [16:0]   qsel;

  always_comb begin
    mx = m_q[0];
    if (m_q[1] > mx) mx = m_q[1];
    if (m_q[2] > mx) mx = m_q[2];
  end

  assign prod  = m_q[ci_q][30:0] * m_q[ci_q][30:0];
  assign trial = {rem_q[60:0], sum_q[61:60]} - {root_q, 2'b01};
  assign dtry  = {dr_q, num_q[45]} - {15'd0, root_q};
  assign numer = {m_q[ci_q][30:0], 14'd0} + {16'd0, root_q[31:1]};

  always_comb begin
    st_d = st_q; ci_d = ci_q; cnt_d = cnt_q;
    sum_d = sum_q; rem_d = rem_q; root_d = root_q;
    dr_d = dr_q; num_d = num_q;
    m_d = m_q; q_d = q_q;
    qsel = '0;
    unique case (st_q)
      S_IDLE: begin
        if (start_i) begin
          m_d[0] = mag0_i; m_d[1] = mag1_i; m_d[2] = mag2_i;
          st_d = S_ALN;
        end
      end
      S_ALN: begin
        if (mx >= (MW'(1) << 30)) begin
          for (int i = 0; i < 3; i++) m_d[i] = m_q[i] >> 1;
        end else if (mx < (MW'(1) << 29)) begin
          for (int i = 0; i < 3; i++) m_d[i] = m_q[i] << 1;
        end else begin
          st_d = S_SQ; ci_d = 2'd0; sum_d = '0;
        end
      end
      S_SQ: begin
        sum_d = sum_q + 63'(prod);
        if (ci_q == 2'd2) begin
          st_d = S_SQRT; cnt_d = 6'd0; rem_d = '0; root_d = '0;
        end else ci_d = ci_q + 2'd1;
      end
      S_SQRT: begin
        // one root bit per cycle, two radicand bits shifted in
        sum_d = {sum_q[60:0], 2'b00};
        if (!trial[63]) begin
          rem_d  = trial[62:0];
          root_d = {root_q[30:0], 1'b1};
        end else begin
          rem_d  = {rem_q[60:0], sum_q[61:60]};
          root_d = {root_q[30:0], 1'b0};
        end
        if (cnt_q == 6'd30) begin
          st_d = S_DIV; ci_d = 2'd0; cnt_d = 6'd0;
          num_d = numer[45:0]; dr_d = '0;
        end else cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd30) num_d = '0;
      end
      S_DIV: begin
        if (cnt_q == 6'd0 && num_q == '0 && dr_q == '0) begin
          num_d = numer[45:0];
          cnt_d = 6'd1;
        end else begin
          num_d = {num_q[44:0], ~dtry[46]};
          dr_d  = dtry[46] ? {dr_q[44:0], num_q[45]} : dtry[45:0];
          if (cnt_q == 6'd46) begin
            qsel = {num_q[15:0], ~dtry[46]};
            q_d[ci_q] = (qsel > 17'd16384) ? 16'd16384 : qsel[15:0];
            dr_d = '0; num_d = '0; cnt_d = 6'd0;
            if (ci_q == 2'd2) st_d = S_DONE;
            else ci_d = ci_q + 2'd1;
          end else cnt_d = cnt_q + 6'd1;
        end
      end
      S_DONE: st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ci_q <= '0; cnt_q <= '0;
    end else begin
      st_q <= st_d; ci_q <= ci_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d; rem_q <= rem_d; root_q <= root_d;
    dr_q <= dr_d; num_q <= num_d; m_q <= m_d; q_q <= q_d;
  end

  assign done_o = (st_q == S_DONE);
  assign busy_o = (st_q != S_IDLE);
  assign q0_o = q_q[0];
  assign q1_o = q_q[1];
  assign q2_o = q_q[2];

`ifndef SYNTHESIS
  a_done_from_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(st_q) == S_DIV) else $error("done without division");
  a_q_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (q0_o <= 16'd16384 && q1_o <= 16'd16384 && q2_o <= 16'd16384))
    else $error("quotient above unit");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_o) else $error("start while busy");
`endif
endmodule
`default_nettype wire

// File: design/triangle_face_normal_engine_core.sv
`default_nettype none
// Write beats are accepted one per cycle while the core is idle and holds no result. A compute
// beat fetches the three corners, forms the cross product terms and their differences, then runs
// the normalizer: start, alignment shifts, squares, square root bits, serial divide steps per
// component and a handoff. A zero cross product skips the normalizer and is flagged degenerate;
// the next beat is taken once the result beat has left.
// Reset is asynchronous active low and clears control only; both stores start undefined.
module triangle_face_normal_engine_core #(
  parameter int unsigned VERTEX_DEPTH  = tfn_pkg::VERTEX_DEPTH_DEF,
  parameter int unsigned SURFACE_DEPTH = tfn_pkg::SURFACE_DEPTH_DEF,
  parameter int unsigned COORD_WIDTH   = tfn_pkg::COORD_WIDTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tfn_in_if.sink    in_i,
  tfn_out_if.source out_o
);
  localparam int unsigned VAW = (VERTEX_DEPTH  > 1) ? $clog2(VERTEX_DEPTH)  : 1;
  localparam int unsigned SAW = (SURFACE_DEPTH > 1) ? $clog2(SURFACE_DEPTH) : 1;
  localparam int unsigned DW  = COORD_WIDTH + 1;
  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned MW  = PW + 1;
  localparam int unsigned IW  = tfn_pkg::IDX_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FT   = 3'd1;
  localparam logic [2:0] S_FV   = 3'd2;
  localparam logic [2:0] S_CR   = 3'd3;
  localparam logic [2:0] S_MAG  = 3'd4;
  localparam logic [2:0] S_NRM  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [3*COORD_WIDTH-1:0] vmem [VERTEX_DEPTH];
  logic [3*IW-1:0]          tmem [SURFACE_DEPTH];

  logic [2:0]  st_q, st_d;
  logic [1:0]  k_q, k_d;
  logic [3*IW-1:0] tri_q;
  logic [3*COORD_WIDTH-1:0] vrd_q;
  logic [VAW-1:0] vaddr;
  logic [IW-1:0]  vsel;
  logic           vok_q;
  logic signed [COORD_WIDTH-1:0] p_q [3][3];
  logic signed [DW-1:0] u [3];
  logic signed [DW-1:0] w [3];
  logic signed [PW-1:0] pr_q [6];
  logic [1:0]           pk_q;
  logic signed [MW-1:0] cr_q [3];
  logic                 out_v_q;
  tfn_pkg::out_item_t   out_q;
  tfn_pkg::nrm_ctl_t    nc;
  logic [15:0] q0, q1, q2;
  logic [MW-1:0] mg [3];

  wire acc = in_i.valid && in_i.ready;
  assign in_i.ready = (st_q == S_IDLE) && !out_v_q;

  always_ff @(posedge clk_i) begin
    if (acc && in_i.data.mode == tfn_pkg::MODE_WR_VERTEX &&
        32'(in_i.data.vertex_index) < VERTEX_DEPTH)
      vmem[in_i.data.vertex_index[VAW-1:0]] <= {in_i.data.pos_x[COORD_WIDTH-1:0],
        in_i.data.pos_y[COORD_WIDTH-1:0], in_i.data.pos_z[COORD_WIDTH-1:0]};
    if (acc && in_i.data.mode == tfn_pkg::MODE_WR_SURFACE &&
        32'(in_i.data.surface_index) < SURFACE_DEPTH)
      tmem[in_i.data.surface_index[SAW-1:0]] <= {in_i.data.corner_a,
        in_i.data.corner_b, in_i.data.corner_c};
    if (acc) tri_q <= tmem[in_i.data.surface_index[SAW-1:0]];
    vrd_q <= vmem[vaddr];
  end

  always_comb begin
    unique case (k_q)
      2'd0:    vsel = tri_q[3*IW-1:2*IW];
      2'd1:    vsel = tri_q[2*IW-1:IW];
      default: vsel = tri_q[IW-1:0];
    endcase
    vaddr = vsel[VAW-1:0];
  end

  for (genvar i = 0; i < 3; i++) begin : g_diff
    assign u[i] = DW'(p_q[1][i]) - DW'(p_q[0][i]);
    assign w[i] = DW'(p_q[2][i]) - DW'(p_q[0][i]);
    assign mg[i] = cr_q[i][MW-1] ? MW'(-cr_q[i]) : MW'(cr_q[i]);
  end

  always_comb begin
    st_d = st_q; k_d = k_q;
    unique case (st_q)
      S_IDLE: if (acc && in_i.data.mode == tfn_pkg::MODE_COMPUTE &&
                  32'(in_i.data.surface_index) < SURFACE_DEPTH) begin
                st_d = S_FT; k_d = 2'd0;
              end
      S_FT:  st_d = S_FV;
      S_FV:  begin
               if (k_q == 2'd2) begin st_d = S_CR; k_d = 2'd0; end
               else begin k_d = k_q + 2'd1; st_d = S_FT; end
             end
      S_CR:  begin
               if (k_q == 2'd2) st_d = S_MAG;
               else k_d = k_q + 2'd1;
             end
      S_MAG: st_d = S_NRM;
      S_NRM: if (nc.done) st_d = S_OUT;
      S_OUT: st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  // S_FT issues the read, S_FV captures it in the next cycle
  always_ff @(posedge clk_i) begin
    if (st_q == S_FT) vok_q <= 32'(vsel) < VERTEX_DEPTH;
    if (st_q == S_FV) begin
      p_q[k_q][0] <= vok_q ? vrd_q[3*COORD_WIDTH-1:2*COORD_WIDTH] : '0;
      p_q[k_q][1] <= vok_q ? vrd_q[2*COORD_WIDTH-1:COORD_WIDTH] : '0;
      p_q[k_q][2] <= vok_q ? vrd_q[COORD_WIDTH-1:0] : '0;
    end
    if (st_q == S_CR) begin
      unique case (k_q)
        2'd0: begin pr_q[0] <= u[1] * w[2]; pr_q[1] <= u[2] * w[1]; end
        2'd1: begin pr_q[2] <= u[2] * w[0]; pr_q[3] <= u[0] * w[2]; end
        default: begin pr_q[4] <= u[0] * w[1]; pr_q[5] <= u[1] * w[0]; end
      endcase
      pk_q <= k_q;
    end
    if (st_q == S_MAG) begin
      cr_q[0] <= MW'(pr_q[0]) - MW'(pr_q[1]);
      cr_q[1] <= MW'(pr_q[2]) - MW'(pr_q[3]);
      cr_q[2] <= MW'(pr_q[4]) - MW'(pr_q[5]);
    end
  end

  wire zero = (cr_q[0] == '0) && (cr_q[1] == '0) && (cr_q[2] == '0);
  assign nc.start = (st_q == S_NRM) && !nc.busy && !zero && pk_q == 2'd2;

  tfn_norm #(.MW(MW)) u_norm (
    .clk_i, .rst_ni, .start_i(nc.start),
    .mag0_i(mg[0]), .mag1_i(mg[1]), .mag2_i(mg[2]),
    .done_o(nc.done), .busy_o(nc.busy), .q0_o(q0), .q1_o(q1), .q2_o(q2)
  );

  wire fin = (st_q == S_NRM) && (zero || nc.done);

  always_ff @(posedge clk_i) begin
    if (fin) begin
      out_q.out_vertex_a <= tri_q[3*IW-1:2*IW];
      out_q.out_vertex_b <= tri_q[2*IW-1:IW];
      out_q.out_vertex_c <= tri_q[IW-1:0];
      out_q.degenerate   <= zero;
      out_q.normal_x <= zero ? '0 : (cr_q[0][MW-1] ? -q0 : q0);
      out_q.normal_y <= zero ? '0 : (cr_q[1][MW-1] ? -q1 : q1);
      out_q.normal_z <= zero ? '0 : (cr_q[2][MW-1] ? -q2 : q2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; k_q <= '0; out_v_q <= 1'b0;
    end else begin
      st_q <= (fin && zero) ? S_OUT : st_d;
      k_q  <= k_d;
      if (fin) out_v_q <= 1'b1;
      else if (out_o.ready) out_v_q <= 1'b0;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |-> !in_i.ready) else $error("accept while busy");
  a_fin_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |=> st_q == S_OUT) else $error("finish not followed by output");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_o.ready |=> out_v_q) else $error("result dropped");
`endif
endmodule
`default_nettype wire
